// ===== hw/rtl/mma_pkg.sv =====
// Shared constants, types and helpers for the multichannel moving-average filter.
// Used by mma_ring, multichannel_moving_average_top and mma_checker.
`timescale 1ns / 1ps

package mma_pkg;

  localparam int CHANNELS    = 4;
  localparam int DEPTH       = 16;
  localparam int SAMPLE_BITS = 12;
  localparam int FILL_VALUE  = 2048;

  // Port field widths
  localparam int SAMPLE_W  = 12;
  localparam int CHANNEL_W = 2;
  localparam int AVERAGE_W = 12;

  localparam int CH_BITS      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int POS_BITS     = $clog2(DEPTH);
  localparam int RING_ENTRIES = CHANNELS * DEPTH;
  localparam int ADDR_BITS    = $clog2(RING_ENTRIES);
  // Wide enough for DEPTH full-scale samples
  localparam int SUM_BITS     = SAMPLE_BITS + $clog2(DEPTH);

  // Sum / DEPTH as multiply by rounded-up reciprocal; exact for any sum below 2^SUM_BITS
  localparam int DIV_SHIFT = SUM_BITS + $clog2(DEPTH);
  localparam int PROD_BITS = 2 * SUM_BITS + 1;
  localparam longint unsigned RECIP_L =
      ((64'd1 << DIV_SHIFT) + 64'(DEPTH) - 64'd1) / 64'(DEPTH);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;
  typedef logic [POS_BITS-1:0]    pos_t;
  typedef logic [CH_BITS-1:0]     ch_t;
  typedef logic [ADDR_BITS-1:0]   addr_t;
  typedef logic [SUM_BITS:0]      recip_t;

  localparam recip_t  RECIP     = recip_t'(RECIP_L);
  localparam sample_t FILL_S    = sample_t'(FILL_VALUE);
  localparam sum_t    SUM_RESET = sum_t'(longint'(FILL_S) * longint'(DEPTH));

  // Write port of the sample ring
  typedef struct packed {
    logic    en;
    addr_t   addr;
    sample_t data;
  } ring_wr_t;

endpackage

// ===== hw/rtl/multichannel_moving_average_top.sv =====
// Multichannel boxcar moving-average filter, top level. Depends on mma_pkg, mma_ring.
// Pipeline: stage 1 (ring read in flight), then the output register.
// Throughput: one transfer per cycle while the output register is free or draining,
// set by the ring read-modify-write (read at input transfer, write back as stage 1 moves on).
// Reset (rst, synchronous): pipeline empty, positions zero, sums FILL*DEPTH,
// all ring entries read back as the fill value until written.
`timescale 1ns / 1ps

module multichannel_moving_average_top (
  input  logic                             clk,
  input  logic                             rst,
  // input channel
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [mma_pkg::SAMPLE_W-1:0]     sample,
  input  logic [mma_pkg::CHANNEL_W-1:0]    channel,
  // output channel
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mma_pkg::AVERAGE_W-1:0]    average,
  output logic [mma_pkg::CHANNEL_W-1:0]    channel_out
);
  import mma_pkg::*;

  // Channel number folded into 0 .. CHANNELS-1 (identity at four channels)
  function automatic ch_t reduce_channel(input logic [CHANNEL_W-1:0] c);
    logic [CHANNEL_W-1:0] v;
    v = c;
    for (int i = 0; i < 3; i++) begin
      if (int'(v) >= CHANNELS) begin
        v = CHANNEL_W'(int'(v) - CHANNELS);
      end
    end
    return ch_t'(v);
  endfunction

  // Truncated sum / DEPTH, masked to the field width
  function automatic logic [AVERAGE_W-1:0] mean_of(input sum_t s);
    logic [PROD_BITS-1:0] prod;
    prod = PROD_BITS'(s) * PROD_BITS'(RECIP);
    return AVERAGE_W'(prod >> DIV_SHIFT);
  endfunction

  // Per-channel state
  pos_t wpos [CHANNELS];
  sum_t sums [CHANNELS];

  // Stage 1: captured item, ring read in flight
  logic    s1_valid;
  sample_t s1_sample;
  ch_t     s1_ch;
  addr_t   s1_addr;

  logic     in_fire;
  logic     s1_adv;
  ch_t      in_ch;
  sample_t  in_sample;
  pos_t     in_pos;
  addr_t    in_addr;
  sample_t  old_sample;
  sum_t     sum_next;
  ring_wr_t ring_wr;

  // Stage 1 moves on whenever the output register is empty or being drained,
  // so the input stays open back to back while results are taken.
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign in_ch     = reduce_channel(channel);
  assign in_sample = sample_t'(16'(sample));
  assign in_pos    = wpos[in_ch];
  assign in_addr   = ADDR_BITS'(int'(in_ch) * DEPTH + int'(in_pos));

  // Write position advances at the transfer; the ring entry is replaced when
  // stage 1 moves on. Back-to-back items of one channel hit different entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wpos[c] <= '0;
      end
    end else if (in_fire) begin
      wpos[in_ch] <= (int'(in_pos) == DEPTH - 1) ? '0 : POS_BITS'(int'(in_pos) + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample <= in_sample;
      s1_ch     <= in_ch;
      s1_addr   <= in_addr;
    end
  end

  assign ring_wr.en   = s1_valid && s1_adv;
  assign ring_wr.addr = s1_addr;
  assign ring_wr.data = s1_sample;

  mma_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (in_addr),
    .wr      (ring_wr),
    .rd_data (old_sample)
  );

  // Oldest sample out, newest in; the sum never wraps
  assign sum_next = sums[s1_ch] - sum_t'(old_sample) + sum_t'(s1_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        sums[c] <= SUM_RESET;
      end
    end else if (ring_wr.en) begin
      sums[s1_ch] <= sum_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ring_wr.en) begin
      average     <= mean_of(sum_next);
      channel_out <= CHANNEL_W'(s1_ch);
    end
  end

endmodule

// ===== hw/rtl/mma_ring.sv =====
// Sample ring storage for all channels: one write and one registered read per cycle.
// Unwritten entries read as the fill value. Depends on mma_pkg.
`timescale 1ns / 1ps

module mma_ring (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  mma_pkg::addr_t    rd_addr,
  input  mma_pkg::ring_wr_t wr,
  output mma_pkg::sample_t  rd_data
);
  import mma_pkg::*;

  sample_t                 mem [RING_ENTRIES];
  logic [RING_ENTRIES-1:0] written;
  sample_t                 rd_word;
  logic                    rd_written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.en) begin
      written[wr.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word    <= mem[rd_addr];
      rd_written <= written[rd_addr];
    end
  end

  assign rd_data = rd_written ? rd_word : FILL_S;

endmodule

// ===== hw/rtl/mma_checker.sv =====
// Port-level checks for the moving-average filter, bound to the top level.
// Depends on mma_pkg for field widths.
`timescale 1ns / 1ps

module mma_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [mma_pkg::SAMPLE_W-1:0]  sample,
  input logic [mma_pkg::CHANNEL_W-1:0] channel,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [mma_pkg::AVERAGE_W-1:0] average,
  input logic [mma_pkg::CHANNEL_W-1:0] channel_out
);
  import mma_pkg::*;

  // Offered input holds until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(sample) && $stable(channel))
    else $error("input dropped or changed before transfer");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(average) && $stable(channel_out))
    else $error("result changed while stalled");

  // Reset leaves the block empty and open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not empty after reset");

  // A draining output never blocks the input
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  // A transfer reaches the output once the output register is free to take it from stage 1
  a_latency: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready ##1 (out_ready || !out_valid) |=> out_valid)
    else $error("result missing after input transfer");

endmodule

bind multichannel_moving_average_top mma_checker u_mma_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .sample      (sample),
  .channel     (channel),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .average     (average),
  .channel_out (channel_out)
);

// ===== verif/tb_multichannel_moving_average_top.sv =====
// Self-checking testbench for multichannel_moving_average_top: directed table plus random
// samples, every output checked against an in-bench boxcar predictor or a pinned average. Depends on mma_pkg.
`timescale 1ns / 1ps

module tb_multichannel_moving_average_top;
  import mma_pkg::*;

  localparam int NUM_ROWS      = 24;   // directed table length
  localparam int RAND_PER_MODE = 560;  // minimum random samples per idling mode (bursts may overshoot)
  localparam int HOLD_CYCLES   = 200;  // long output stall to back up the pipeline
  localparam int STALL_LIMIT   = 1000; // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES  = 8;    // extra margin after the last expected result

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic [SAMPLE_W-1:0]    sample;
  logic [CHANNEL_W-1:0]   channel;
  logic                   out_valid;
  logic                   out_ready;
  logic [AVERAGE_W-1:0]   average;
  logic [CHANNEL_W-1:0]   channel_out;

  multichannel_moving_average_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample     (sample),
    .channel    (channel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .average    (average),
    .channel_out(channel_out)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // One expected filter output.
  typedef struct packed {
    logic [AVERAGE_W-1:0] avg;
    logic [CHANNEL_W-1:0] ch;
  } avg_result_t;

  // Directed stimulus row. Where pinned is set, pinned_avg is the expected average,
  // read straight off the filter definition; otherwise the predictor supplies it.
  typedef struct packed {
    logic [SAMPLE_W-1:0]  level;
    logic [CHANNEL_W-1:0] chan;
    bit                   pinned;
    logic [AVERAGE_W-1:0] pinned_avg;
  } stim_row_t;

  // After reset every ring holds 2048, so the first sample s on a channel gives
  // (15 * 2048 + s) / 16. Sixteen full-scale samples on one channel give full scale.
  stim_row_t directed_rows [NUM_ROWS] = '{
    '{12'd0,    2'd0, 1'b1, 12'd1920},  // zero into fresh channel
    '{12'd4095, 2'd1, 1'b1, 12'd2175},  // full scale into fresh channel
    '{12'd2048, 2'd2, 1'b1, 12'd2048},  // fill value leaves the mean alone
    '{12'd1,    2'd3, 1'b1, 12'd1920},  // truncation of a fraction
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b0, 12'd0},
    '{12'd4095, 2'd1, 1'b1, 12'd4095}, // ring full of max: largest sum, mean = max
    '{12'd2730, 2'd2, 1'b0, 12'd0},    // alternating bit patterns
    '{12'd1365, 2'd2, 1'b0, 12'd0},
    '{12'd0,    2'd3, 1'b0, 12'd0},
    '{12'd4095, 2'd0, 1'b0, 12'd0},
    '{12'd2048, 2'd0, 1'b0, 12'd0}
  };

  // Predictor state: per-channel sample ring, running sum, write pointer.
  logic [SAMPLE_BITS-1:0] ring_model [CHANNELS][DEPTH];
  sum_t                   sum_model  [CHANNELS];
  int unsigned            wptr_model [CHANNELS];

  avg_result_t expected_q [$];

  int unsigned inputs_taken;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  bit          hold_request;

  // Push one sample into the channel's boxcar and return the new mean.
  function automatic avg_result_t boxcar_update(input logic [SAMPLE_W-1:0] s,
                                                input logic [CHANNEL_W-1:0] c);
    avg_result_t            r;
    int unsigned            ch;
    int unsigned            p;
    logic [SAMPLE_BITS-1:0] kept;
    ch   = int'(c) % CHANNELS;
    p    = wptr_model[ch] % DEPTH;
    kept = SAMPLE_BITS'(s);                 // drop bits above the sample width
    sum_model[ch]     = sum_model[ch] - ring_model[ch][p] + kept;
    ring_model[ch][p] = kept;
    wptr_model[ch]    = (p + 1) % DEPTH;
    r.avg = AVERAGE_W'(int'(sum_model[ch]) / DEPTH);
    r.ch  = CHANNEL_W'(ch);
    return r;
  endfunction

  // Transfer monitor: both handshakes sampled at the rising edge. DUT outputs
  // still hold their pre-edge values here since the RTL updates by NBA.
  always @(posedge clk) begin
    avg_result_t predicted;
    avg_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected output transfer avg=%0d ch=%0d",
                   $time, average, channel_out);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (average !== want.avg) begin
            $display("%0t: average mismatch expected=%0d actual=%0d (ch %0d)",
                     $time, want.avg, average, want.ch);
            mismatches++;
          end
          if (channel_out !== want.ch) begin
            $display("%0t: channel_out mismatch expected=%0d actual=%0d",
                     $time, want.ch, channel_out);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        predicted = boxcar_update(sample, channel);
        // pinned table rows override the predictor's average
        if (inputs_taken < NUM_ROWS && directed_rows[inputs_taken].pinned)
          predicted.avg = directed_rows[inputs_taken].pinned_avg;
        expected_q.push_back(predicted);
        inputs_taken++;
      end
    end
  end

  // Watchdog: any transfer resets the count; a long silence means a hang.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("tb_multichannel_moving_average_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Output side: random backpressure, or one long hold when requested.
  initial begin
    out_ready = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_request = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // Offer one sample; random idle cycles before it, then hold until transfer.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic [CHANNEL_W-1:0] c);
    while ($urandom_range(99) < in_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    sample   <= s;
    channel  <= c;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly uniform samples, with the rails weighted up.
  function automatic logic [SAMPLE_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(4095));
    endcase
  endfunction

  initial begin
    logic [SAMPLE_W-1:0]  lvl;
    logic [CHANNEL_W-1:0] ch;
    int unsigned          burst;
    int unsigned          sent;

    rst           = 1'b1;
    in_valid      = 1'b0;
    sample        = '0;
    channel       = '0;
    inputs_taken  = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    hold_request  = 1'b0;
    in_idle_pct   = 9;
    out_stall_pct = 75;

    for (int c = 0; c < CHANNELS; c++) begin
      sum_model[c]  = sum_t'(FILL_VALUE * DEPTH);
      wptr_model[c] = 0;
      for (int d = 0; d < DEPTH; d++)
        ring_model[c][d] = SAMPLE_BITS'(FILL_VALUE);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_sample(directed_rows[i].level, directed_rows[i].chan);

    // Three idling modes: dense input / heavy backpressure, the reverse, then
    // full rate. The long output hold opens the full-rate mode so the sender
    // keeps offering while the pipeline backs up.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin in_idle_pct = 9;  out_stall_pct = 75; end
        1: begin in_idle_pct = 75; out_stall_pct = 9;  end
        default: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
          hold_request  = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < RAND_PER_MODE) begin
        if ($urandom_range(7) == 0) begin
          // steady level on one channel, long enough to wrap its ring
          lvl   = pick_level();
          ch    = CHANNEL_W'($urandom_range(3));
          burst = $urandom_range(DEPTH, DEPTH + 6);
          repeat (burst) send_sample(lvl, ch);
          sent += burst;
        end else begin
          send_sample(pick_level(), CHANNEL_W'($urandom_range(3)));
          sent++;
        end
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // Drain; the watchdog catches a result that never shows.
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("tb_multichannel_moving_average_top: PASS");
    end else begin
      $display("tb_multichannel_moving_average_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/mma_pkg.sv
hw/rtl/mma_ring.sv
hw/rtl/multichannel_moving_average_top.sv
hw/rtl/mma_checker.sv
verif/tb_multichannel_moving_average_top.sv
